// ===== rtl/scyl_pkg.sv =====
// ----------------------------------------------------------------------------
// scyl_pkg
// Shared constants, register codes and payload types of the cylinder finder.
// ----------------------------------------------------------------------------
package scyl_pkg;

    localparam int COORD_BITS = 18;
    localparam int COUNT_BITS = 11;
    localparam int GAP_BITS   = COORD_BITS - 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = GAP_BITS;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_X      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_Y      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_POINTS = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_POINTS = 2'd3;

    localparam logic [COUNT_BITS-1:0] MIN_POINTS_RST = COUNT_BITS'(30);
    localparam logic [COUNT_BITS-1:0] MAX_POINTS_RST = COUNT_BITS'(50);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [GAP_BITS-1:0]   gap_x_limit;
        logic [GAP_BITS-1:0]   gap_y_limit;
        logic [COUNT_BITS-1:0] min_points;
        logic [COUNT_BITS-1:0] max_points;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         end_of_scan;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [COUNT_BITS-1:0]        point_count;
        logic                         last_of_run;
    } result_t;

    // up to two results per point, slot 0 goes out first
    typedef struct packed {
        logic [1:0]      valid;
        result_t [1:0]   res;
    } result_pair_t;

endpackage

// ===== rtl/scyl_channels.sv =====
// ----------------------------------------------------------------------------
// scyl channels
// Valid/ready channel interfaces for points, results and register writes.
// ----------------------------------------------------------------------------
interface scyl_point_if
    import scyl_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         end_of_scan;

    modport source (output valid, output point_x, output point_y, output end_of_scan,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input end_of_scan,
                    output ready);
endinterface

interface scyl_result_if
    import scyl_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [COUNT_BITS-1:0]        point_count;
    logic                         last_of_run;

    modport source (output valid, output center_x, output center_y, output point_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input center_x, input center_y, input point_count,
                    input last_of_run, output ready);
endinterface

interface scyl_cfg_if
    import scyl_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/scan_cluster_cylinder_finder.sv =====
// ----------------------------------------------------------------------------
// scan_cluster_cylinder_finder
// Jump distance segmentation of a laser scan with cylinder reports.
// ----------------------------------------------------------------------------
// Takes one scan point per clock while input ready is high. A point is
// registered, judged against the open cluster once the queue has room, and
// its results (none, one or two) go into a four-entry queue. The output
// port moves one result per cycle while the receiver is ready; a point that
// both closes a cluster and ends the scan gives two results, which leave one
// after the other, and input ready drops while a point waits in the input
// register and the queue lacks room for a pair of results.
// Registers are written through the cfg channel, which is always ready.
module scan_cluster_cylinder_finder
    import scyl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    scyl_cfg_if.sink      cfg,
    scyl_point_if.sink    points,
    scyl_result_if.source results
);

    cfg_t         cfg_cur;
    point_t       in_data;
    result_pair_t push;
    logic         space_ok;
    result_t      out_data;

    scyl_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    assign in_data.point_x     = points.point_x;
    assign in_data.point_y     = points.point_y;
    assign in_data.end_of_scan = points.end_of_scan;

    scyl_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_cur),
        .in_valid (points.valid),
        .in_ready (points.ready),
        .in_data  (in_data),
        .space_ok (space_ok),
        .push     (push)
    );

    scyl_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_data)
    );

    assign results.center_x    = out_data.center_x;
    assign results.center_y    = out_data.center_y;
    assign results.point_count = out_data.point_count;
    assign results.last_of_run = out_data.last_of_run;

endmodule

// ===== rtl/scyl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scyl_cfg_regs
// Gap limits and point count bounds, written through the register channel.
// ----------------------------------------------------------------------------
module scyl_cfg_regs
    import scyl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_valid,
    output logic                      wr_ready,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_x_limit <= '0;
            cfg_reg.gap_y_limit <= '0;
            cfg_reg.min_points  <= MIN_POINTS_RST;
            cfg_reg.max_points  <= MAX_POINTS_RST;
        end
        else if (wr_valid && wr_ready)
        begin
            unique case (wr_index)
                CFG_GAP_X:      cfg_reg.gap_x_limit <= wr_data[GAP_BITS-1:0];
                CFG_GAP_Y:      cfg_reg.gap_y_limit <= wr_data[GAP_BITS-1:0];
                CFG_MIN_POINTS: cfg_reg.min_points  <= wr_data[COUNT_BITS-1:0];
                CFG_MAX_POINTS: cfg_reg.max_points  <= wr_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/scyl_core.sv =====
// ----------------------------------------------------------------------------
// scyl_core
// Input stage, cluster state and the close / flush decision for one point.
// ----------------------------------------------------------------------------
module scyl_core
    import scyl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  point_t       in_data,
    input  logic         space_ok,
    output result_pair_t push
);

    point_t                       stage_reg;
    logic                         stage_valid_reg;
    logic                         stage_valid_next;

    logic                         cluster_open_reg;
    logic                         cluster_open_next;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_x_next;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic signed [COORD_BITS-1:0] first_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] prev_y_next;
    logic [COUNT_BITS-1:0]        cluster_count_reg;
    logic [COUNT_BITS-1:0]        cluster_count_next;

    logic                         accept;
    logic                         process;
    logic signed [DIFF_BITS-1:0]  diff_x;
    logic signed [DIFF_BITS-1:0]  diff_y;
    logic [DIFF_BITS-1:0]         mag_x;
    logic [DIFF_BITS-1:0]         mag_y;
    logic                         join_pt;
    logic                         close_pt;
    logic                         old_ok;
    logic                         new_ok;
    logic                         emit_close;
    logic                         emit_flush;
    logic [DIFF_BITS-1:0]         sum_old_x;
    logic [DIFF_BITS-1:0]         sum_old_y;
    logic [DIFF_BITS-1:0]         sum_new_x;
    logic [DIFF_BITS-1:0]         sum_new_y;

    assign accept   = in_valid && in_ready;
    assign process  = stage_valid_reg && space_ok;
    assign in_ready = !stage_valid_reg || space_ok;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (process)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= in_data;
    end

    // jump distance test against the previous point
    assign diff_x = {stage_reg.point_x[COORD_BITS-1], stage_reg.point_x}
                  - {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign diff_y = {stage_reg.point_y[COORD_BITS-1], stage_reg.point_y}
                  - {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign mag_x  = diff_x[DIFF_BITS-1] ? DIFF_BITS'(-diff_x) : DIFF_BITS'(diff_x);
    assign mag_y  = diff_y[DIFF_BITS-1] ? DIFF_BITS'(-diff_y) : DIFF_BITS'(diff_y);

    assign join_pt  = cluster_open_reg
                   && (mag_x <= {2'b00, cfg.gap_x_limit})
                   && (mag_y <= {2'b00, cfg.gap_y_limit});
    assign close_pt = cluster_open_reg && !join_pt;

    assign old_ok = (cluster_count_reg >= cfg.min_points)
                 && (cluster_count_reg <= cfg.max_points);

    always_comb
    begin
        first_x_next       = first_x_reg;
        first_y_next       = first_y_reg;
        prev_x_next        = stage_reg.point_x;
        prev_y_next        = stage_reg.point_y;
        cluster_count_next = COUNT_BITS'(1);
        if (join_pt)
        begin
            if (cluster_count_reg != COUNT_MAX)
                cluster_count_next = cluster_count_reg + 1'b1;
            else
                cluster_count_next = cluster_count_reg;
        end
        else
        begin
            first_x_next = stage_reg.point_x;
            first_y_next = stage_reg.point_y;
        end
        cluster_open_next = !stage_reg.end_of_scan;
    end

    assign new_ok = (cluster_count_next >= cfg.min_points)
                 && (cluster_count_next <= cfg.max_points);

    assign emit_close = close_pt && (prev_x_reg <= stage_reg.point_x) && old_ok;
    assign emit_flush = stage_reg.end_of_scan && new_ok;

    // floor midpoint: take the sum one bit wider and drop the lsb
    assign sum_old_x = {first_x_reg[COORD_BITS-1], first_x_reg}
                     + {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign sum_old_y = {first_y_reg[COORD_BITS-1], first_y_reg}
                     + {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign sum_new_x = {first_x_next[COORD_BITS-1], first_x_next}
                     + {prev_x_next[COORD_BITS-1], prev_x_next};
    assign sum_new_y = {first_y_next[COORD_BITS-1], first_y_next}
                     + {prev_y_next[COORD_BITS-1], prev_y_next};

    always_comb
    begin
        push.valid              = {process && emit_flush, process && emit_close};
        push.res[0].center_x    = sum_old_x[DIFF_BITS-1:1];
        push.res[0].center_y    = sum_old_y[DIFF_BITS-1:1];
        push.res[0].point_count = cluster_count_reg;
        push.res[0].last_of_run = !emit_flush;
        push.res[1].center_x    = sum_new_x[DIFF_BITS-1:1];
        push.res[1].center_y    = sum_new_y[DIFF_BITS-1:1];
        push.res[1].point_count = cluster_count_next;
        push.res[1].last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_open_reg  <= 1'b0;
            first_x_reg       <= '0;
            first_y_reg       <= '0;
            prev_x_reg        <= '0;
            prev_y_reg        <= '0;
            cluster_count_reg <= '0;
        end
        else if (process)
        begin
            cluster_open_reg  <= cluster_open_next;
            first_x_reg       <= first_x_next;
            first_y_reg       <= first_y_next;
            prev_x_reg        <= prev_x_next;
            prev_y_reg        <= prev_y_next;
            cluster_count_reg <= cluster_count_next;
        end
    end

`ifndef SYNTHESIS
    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        process && stage_reg.end_of_scan |=> !cluster_open_reg)
        else $error("cluster still open after end of scan");

    a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cluster_open_reg |-> cluster_count_reg != '0)
        else $error("open cluster with zero points");

    a_point_opens: assert property (@(posedge clk) disable iff (!rst_n)
        process && !stage_reg.end_of_scan |=> cluster_open_reg)
        else $error("point did not leave a cluster open");

    a_no_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid[0] |-> cluster_open_reg && cluster_count_reg != '0)
        else $error("cluster closed while none was open");
`endif

endmodule

// ===== rtl/scyl_out_queue.sv =====
// ----------------------------------------------------------------------------
// scyl_out_queue
// Small result queue: takes up to two results a cycle, hands out one while the receiver is ready.
// ----------------------------------------------------------------------------
module scyl_out_queue
    import scyl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    output logic         space_ok,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_data
);

    result_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic [QCNT_BITS-1:0] push_n;
    logic                 pop;

    assign push_n     = QCNT_BITS'(push.valid[0]) + QCNT_BITS'(push.valid[1]);
    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && out_ready;
    assign out_data   = mem_reg[rd_ptr_reg];
    // room for a worst-case pair of results
    assign space_ok   = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign count_next = count_reg + push_n - QCNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.valid[0])
            mem_reg[wr_ptr_reg] <= push.res[0];
        if (push.valid[1])
            mem_reg[wr_ptr_reg + PTR_BITS'(push.valid[0])] <= push.res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(pop);
            count_reg  <= count_next;
        end
    end

endmodule
